// File: hdl/message_ring_queue_assert.svh
// Assertion macros shared by the message ring queue modules.
// Each macro expects clock clk and synchronous reset rst in scope.
`ifndef MESSAGE_RING_QUEUE_ASSERT_SVH
`define MESSAGE_RING_QUEUE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define MRQ_CHECK_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("message_ring_queue: invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define MRQ_CHECK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("message_ring_queue: same-cycle implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define MRQ_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("message_ring_queue: next-cycle implication violated");

`endif

// File: hdl/mrq_pkg.sv
package mrq_pkg;

  // Requested action codes.
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_DROP   = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture the result status of an accepted item
    logic    wr_byte;    // write the appended byte and advance the position
    logic    wr_term;    // write the zero terminator at the position
    logic    rd;         // read a byte of the head message
    logic    adv_write;  // commit: advance the write slot
    logic    adv_read;   // drop: advance the read slot
    status_t code;
  } dp_cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic overflow;
    logic full;
    logic empty;
  } dp_flags_t;

endpackage

// File: hdl/mrq_ram.sv
module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/mrq_ctrl.sv
`include "message_ring_queue_assert.svh"

module mrq_ctrl import mrq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  dp_flags_t  flags,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_TERM   = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t  state;
  state_t  state_next;
  action_t act;

  assign act  = action_t'(action);
  assign busy = (state == S_TERM);
  assign done = (state == S_REPORT);

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE, S_REPORT: begin
        state_next = S_IDLE;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_REPORT;
          unique case (act)
            ACT_APPEND: begin
              if (flags.overflow) begin
                cmd.code = ST_OVERFLOW;
              end else begin
                cmd.wr_byte = 1'b1;
                state_next  = S_TERM;
              end
            end
            ACT_COMMIT: begin
              if (flags.full) begin
                cmd.code = ST_FULL;
              end else begin
                cmd.adv_write = 1'b1;
              end
            end
            ACT_READ: begin
              if (flags.empty) begin
                cmd.code = ST_EMPTY;
              end else begin
                cmd.rd = 1'b1;
              end
            end
            ACT_DROP: begin
              if (flags.empty) begin
                cmd.code = ST_EMPTY;
              end else begin
                cmd.adv_read = 1'b1;
              end
            end
            default: cmd.code = ST_OK;
          endcase
        end
      end
      S_TERM: begin
        cmd.wr_term = 1'b1;
        state_next  = S_REPORT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MRQ_CHECK_NEXT(a_append_writes_term,
                  start && !busy && action == ACT_APPEND && !flags.overflow,
                  state == S_TERM)
  `MRQ_CHECK_IMPL(a_done_has_cause, done,
                  $past(start && !busy) || $past(state == S_TERM))
  `MRQ_CHECK_NEXT(a_term_then_report, state == S_TERM, done)

endmodule

// File: hdl/mrq_dp.sv
`include "message_ring_queue_assert.svh"

module mrq_dp import mrq_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  input  logic [7:0] data_byte,
  input  logic [5:0] byte_index,
  output dp_flags_t  flags,
  output logic [7:0] head_byte,
  output logic [1:0] status,
  output logic       is_empty,
  output logic [2:0] message_count
);

  localparam int SW    = $clog2(SLOTS);
  localparam int PW    = $clog2(SLOT_BYTES);
  localparam int AW    = SW + PW;
  localparam int DEPTH = 2 ** AW;

  logic [SW-1:0] write_slot;
  logic [SW-1:0] read_slot;
  logic [SW-1:0] held_count;
  logic [PW-1:0] write_position;
  logic [SW-1:0] write_slot_next;
  logic [SW-1:0] read_slot_next;
  logic          idx_ok;
  logic          head_use;
  status_t       status_reg;
  logic [7:0]    rdata;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_wdata;

  assign write_slot_next = (write_slot == SW'(SLOTS - 1)) ? '0 : write_slot + SW'(1);
  assign read_slot_next  = (read_slot == SW'(SLOTS - 1)) ? '0 : read_slot + SW'(1);

  // An append needs room for the byte and the terminator behind it.
  assign flags.overflow = ({1'b0, write_position} + (PW + 1)'(1)) >= (PW + 1)'(SLOT_BYTES);
  assign flags.full     = (write_slot_next == read_slot);
  assign flags.empty    = (held_count == '0);

  assign idx_ok = {26'd0, byte_index} < 32'(SLOT_BYTES);

  // The terminator is written in the S_TERM state that follows the byte, at the advanced position.
  assign ram_we    = cmd.wr_byte | cmd.wr_term;
  assign ram_waddr = {write_slot, write_position};
  assign ram_wdata = cmd.wr_term ? 8'd0 : data_byte;
  assign ram_re    = cmd.rd & idx_ok;
  assign ram_raddr = {read_slot, PW'(byte_index)};

  mrq_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      read_slot      <= '0;
      held_count     <= '0;
      write_position <= '0;
    end else begin
      if (cmd.wr_byte) begin
        write_position <= write_position + PW'(1);
      end
      if (cmd.adv_write) begin
        write_slot     <= write_slot_next;
        held_count     <= held_count + SW'(1);
        write_position <= '0;
      end
      if (cmd.adv_read) begin
        read_slot  <= read_slot_next;
        held_count <= held_count - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_reg <= cmd.code;
      head_use   <= cmd.rd & idx_ok;
    end
  end

  assign head_byte     = head_use ? rdata : 8'd0;
  assign status        = status_reg;
  assign is_empty      = (held_count == '0);
  assign message_count = 3'(held_count);

  `MRQ_CHECK_ALWAYS(a_held_bound, held_count <= SW'(SLOTS - 1))
  `MRQ_CHECK_ALWAYS(a_ring_consistent, (held_count == '0) == (write_slot == read_slot))
  `MRQ_CHECK_NEXT(a_commit_clears_pos, cmd.adv_write, write_position == '0)

endmodule

// File: hdl/message_ring_queue.sv
// Message ring queue: a ring of SLOTS message slots, SLOT_BYTES bytes each.
// An item is accepted at a rising clock edge where start is high and busy is
// low. The item carries an action (append, commit, read head byte, drop head),
// the byte to append and the index of the head byte to read.
// Each accepted item produces exactly one result, shown for one cycle with
// done high: head_byte, status, is_empty and message_count, the last two
// taken after the action has taken effect. The receiver cannot stall; a
// result that is not taken in its cycle is gone.
// Commit, read and drop have their result shown in the cycle after
// acceptance. An append writes its byte and then its zero terminator
// through the single write port of the slot store, so busy is high for one
// cycle and the result is shown after the terminator has been written.
// A new item may be accepted in the cycle in which the previous result is
// shown, so commit, read and drop sustain one item per cycle; an append
// holds the next item off while busy is high.
// Reset clears the slot pointers, the message count and the write position.
// The slot store itself is not cleared; bytes never written read as anything.
module message_ring_queue import mrq_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic [5:0] byte_index,
  output logic       done,
  output logic [7:0] head_byte,
  output logic [1:0] status,
  output logic       is_empty,
  output logic [2:0] message_count
);

  dp_cmd_t   cmd;
  dp_flags_t flags;

  // The controller sequences each item; the datapath owns the pointers,
  // the slot store and the result registers.
  mrq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(action),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mrq_dp #(
    .SLOTS     (SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .flags        (flags),
    .head_byte    (head_byte),
    .status       (status),
    .is_empty     (is_empty),
    .message_count(message_count)
  );

endmodule

// File: dv/message_ring_queue_tb.sv
module message_ring_queue_tb import mrq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default geometry: 8 slots of 64 bytes.
  localparam int SLOTS        = 8;
  localparam int SLOT_BYTES   = 64;
  localparam int RANDOM_ITEMS = 900;
  // The last stretch of the run is sent back to back, with no sender idling.
  localparam int QUIET_ITEMS  = 150;
  // Every so often the sender holds off until all results are back.
  localparam int DRAIN_EVERY  = 250;
  // This leaves a wide margin over the slowest correct run, in which every
  // item follows the longest idle gap and is an append.
  localparam int CYCLE_LIMIT  = 200000;

  // One result of the block, as the predictor works it out.
  typedef struct packed {
    logic [7:0] head;
    status_t    code;
    logic       empty;
    logic [2:0] count;
  } result_t;

  // One row of the directed table. Rows with typed set carry their own
  // expected result; the others take the predictor's.
  typedef struct {
    action_t    act;
    logic [7:0] data;
    logic [5:0] idx;
    bit         typed;
    result_t    want;
  } step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] action = 2'd0;
  logic [7:0] data_byte = 8'd0;
  logic [5:0] byte_index = 6'd0;
  logic       busy;
  logic       done;
  logic [7:0] head_byte;
  logic [1:0] status;
  logic       is_empty;
  logic [2:0] message_count;

  message_ring_queue dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .done          (done),
    .head_byte     (head_byte),
    .status        (status),
    .is_empty      (is_empty),
    .message_count (message_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue state as the predictor sees it. The byte store keeps a second
  // array that marks which entries have ever been written, so that the
  // stimulus never reads a byte whose value the block leaves undefined.
  logic [7:0] slot_bytes [SLOTS][SLOT_BYTES];
  bit         byte_known [SLOTS][SLOT_BYTES];
  int         open_slot;
  int         head_slot;
  int         held;
  int         fill_pos;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  int  errors = 0;
  int  cycles = 0;
  int  sent = 0;
  bit  calm = 1'b0;
  bit  drain_next = 1'b0;

  function automatic int ring_next(int s);
    return (s + 1 == SLOTS) ? 0 : s + 1;
  endfunction

  // Applies one action to the queue state and returns the result it causes.
  // The empty flag and count are taken after the action.
  function automatic result_t apply_action(action_t act, logic [7:0] data,
                                           logic [5:0] idx);
    result_t r;
    r.head = 8'd0;
    r.code = ST_OK;
    case (act)
      ACT_APPEND: begin
        // The byte and its terminator must both fit in the slot.
        if (fill_pos + 1 >= SLOT_BYTES) begin
          r.code = ST_OVERFLOW;
        end else begin
          slot_bytes[open_slot][fill_pos] = data;
          byte_known[open_slot][fill_pos] = 1'b1;
          fill_pos++;
          slot_bytes[open_slot][fill_pos] = 8'd0;
          byte_known[open_slot][fill_pos] = 1'b1;
        end
      end
      ACT_COMMIT: begin
        // One slot always stays free, so SLOTS-1 messages fill the ring.
        if (ring_next(open_slot) == head_slot) begin
          r.code = ST_FULL;
        end else begin
          open_slot = ring_next(open_slot);
          held++;
          fill_pos = 0;
        end
      end
      ACT_READ: begin
        if (held == 0) r.code = ST_EMPTY;
        else r.head = slot_bytes[head_slot][idx];
      end
      default: begin
        if (held == 0) begin
          r.code = ST_EMPTY;
        end else begin
          head_slot = ring_next(head_slot);
          held--;
        end
      end
    endcase
    r.empty = (held == 0);
    r.count = held[2:0];
    return r;
  endfunction

  // Picks an index that may be read from the head message: any index when
  // the queue is empty, otherwise one that has been written. Returns -1 when
  // the head slot holds no written byte at all.
  function automatic int legal_read_index();
    int cand[$];
    if (held == 0) return $urandom_range(0, 63);
    for (int i = 0; i < SLOT_BYTES; i++) begin
      if (byte_known[head_slot][i]) cand.push_back(i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // Sender idling: occasional idle bursts, none in calm stretches and none
  // in the last part of the run.
  function automatic int idle_gap();
    if (calm || sent >= 25 + RANDOM_ITEMS - QUIET_ITEMS) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  function automatic step_t row(action_t a, logic [7:0] d, logic [5:0] i,
                                bit fx = 1'b0, logic [7:0] h = 8'd0,
                                status_t s = ST_OK, logic e = 1'b0,
                                logic [2:0] c = 3'd0);
    step_t st;
    st.act = a;
    st.data = d;
    st.idx = i;
    st.typed = fx;
    st.want = '{h, s, e, c};
    return st;
  endfunction

  // Presents one item and holds it until the block takes it. The item is
  // taken at the first rising edge where start is high and busy is low; the
  // expected result is queued at that same edge. start is lowered only when
  // an idle gap or a drain follows, so it never gets two assignments in one
  // time step.
  task automatic send_item(action_t act, logic [7:0] data, logic [5:0] idx,
                           bit typed = 1'b0, result_t want = '0);
    int gap;
    result_t r;
    gap = idle_gap();
    if (drain_next) begin
      start <= 1'b0;
      do @(posedge clk); while (pending_results.size() != 0);
      drain_next = 1'b0;
    end else if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    data_byte  <= data;
    byte_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    r = apply_action(act, data, idx);
    pending_results.push_back(typed ? want : r);
    sent++;
  endtask

  // A read of the head that never touches an unwritten byte. When the head
  // message has nothing written in it, the item becomes a drop instead.
  task automatic send_read();
    int idx;
    idx = legal_read_index();
    if (idx < 0) send_item(ACT_DROP, 8'($urandom), 6'($urandom));
    else send_item(ACT_READ, 8'($urandom), 6'(idx));
  endtask

  // Result checker. The block shows each result for exactly one cycle with
  // done high, and it is taken at the edge that ends that cycle.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: head_byte %0h status %0d", head_byte, status);
        errors++;
      end else begin
        result_t w;
        w = pending_results.pop_front();
        if (head_byte !== w.head) begin
          $error("head_byte: expected %0h, got %0h", w.head, head_byte);
          errors++;
        end
        if (status !== w.code) begin
          $error("status: expected %0d, got %0d", w.code, status);
          errors++;
        end
        if (is_empty !== w.empty) begin
          $error("is_empty: expected %0d, got %0d", w.empty, is_empty);
          errors++;
        end
        if (message_count !== w.count) begin
          $error("message_count: expected %0d, got %0d", w.count, message_count);
          errors++;
        end
      end
    end
  end

  // Watchdog for a block that stops answering or never drops busy.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("message_ring_queue regression: fail");
      $finish;
    end
  end

  initial begin
    step_t   plan[$];
    int      n;
    int      len;
    action_t act;

    open_slot = 0;
    head_slot = 0;
    held = 0;
    fill_pos = 0;
    foreach (byte_known[s, b]) byte_known[s][b] = 1'b0;

    // Directed part. It opens on an empty queue (read and drop both refused),
    // builds one message with the extreme byte values, reads it back up to
    // and including its terminator, then commits empty messages until the
    // ring is full and one more commit is refused. An append while full
    // still goes into the open slot, and a drop makes room again.
    plan.push_back(row(ACT_READ,   8'h00, 6'd63, 1, 8'h00, ST_EMPTY, 1, 3'd0));
    plan.push_back(row(ACT_DROP,   8'h00, 6'd0,  1, 8'h00, ST_EMPTY, 1, 3'd0));
    plan.push_back(row(ACT_APPEND, 8'hFF, 6'd0,  1, 8'h00, ST_OK,    1, 3'd0));
    plan.push_back(row(ACT_APPEND, 8'h00, 6'd63, 1, 8'h00, ST_OK,    1, 3'd0));
    plan.push_back(row(ACT_APPEND, 8'hA5, 6'd21));
    plan.push_back(row(ACT_COMMIT, 8'h00, 6'd0,  1, 8'h00, ST_OK,    0, 3'd1));
    plan.push_back(row(ACT_READ,   8'h00, 6'd0,  1, 8'hFF, ST_OK,    0, 3'd1));
    plan.push_back(row(ACT_READ,   8'hFF, 6'd1,  1, 8'h00, ST_OK,    0, 3'd1));
    plan.push_back(row(ACT_READ,   8'h00, 6'd3,  1, 8'h00, ST_OK,    0, 3'd1));
    plan.push_back(row(ACT_READ,   8'h00, 6'd2));
    for (int c = 2; c <= SLOTS - 1; c++) begin
      plan.push_back(row(ACT_COMMIT, 8'h00, 6'd0, 1, 8'h00, ST_OK, 0, 3'(c)));
    end
    plan.push_back(row(ACT_COMMIT, 8'hFF, 6'd63, 1, 8'h00, ST_FULL, 0, 3'd7));
    plan.push_back(row(ACT_APPEND, 8'h5A, 6'd0));
    plan.push_back(row(ACT_DROP,   8'h00, 6'd0,  1, 8'h00, ST_OK,    0, 3'd6));
    plan.push_back(row(ACT_COMMIT, 8'h00, 6'd0));
    plan.push_back(row(ACT_DROP,   8'h00, 6'd0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The directed rows go back to back.
    calm = 1'b1;
    foreach (plan[k]) begin
      send_item(plan[k].act, plan[k].data, plan[k].idx, plan[k].typed, plan[k].want);
    end
    drain_next = 1'b1;

    // Random part, built from short well-formed sequences: a message of a
    // few bytes (now and then one long enough to run out of room) closed by
    // a commit, a few reads of the head, a few drops, or a lone item with
    // random fields. Reads only touch bytes that have been written.
    while (sent < plan.size() + RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if (sent % DRAIN_EVERY < 8) drain_next = 1'b1;
      n = $urandom_range(0, 99);
      if (n < 38) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 68) : $urandom_range(0, 8);
        repeat (len) send_item(ACT_APPEND, 8'($urandom), 6'($urandom));
        send_item(ACT_COMMIT, 8'($urandom), 6'($urandom));
      end else if (n < 68) begin
        repeat ($urandom_range(1, 4)) send_read();
      end else if (n < 90) begin
        repeat ($urandom_range(1, 3)) send_item(ACT_DROP, 8'($urandom), 6'($urandom));
      end else begin
        act = action_t'($urandom_range(0, 3));
        if (act == ACT_READ) send_read();
        else send_item(act, 8'($urandom), 6'($urandom));
      end
    end

    // Wind down: wait for every owed result, then let the clock run on so that
    // a stray result from the block would still be caught.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("message_ring_queue regression: pass");
    end else begin
      $display("message_ring_queue regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/mrq_pkg.sv
hdl/mrq_ram.sv
hdl/mrq_ctrl.sv
hdl/mrq_dp.sv
hdl/message_ring_queue.sv
dv/message_ring_queue_tb.sv
